// File: rtl/core/bwf_pkg.sv
// Shared constants, codes and the edge-strength function of the 3x3 binary window filter.
`default_nettype none

package bwf_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	// configuration register fields are fixed at 12 bits
	localparam int SIZE_W    = 12;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int OUT_ROW_W = $clog2(MAX_HEIGHT);
	// flush items may carry the input row past the frame height
	localparam int ROW_W     = $clog2(MAX_HEIGHT + MAX_WIDTH + 2);
	localparam int OWED_W    = $clog2(MAX_WIDTH + 2);
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam int SOBEL_LIMIT = 4;
	localparam int EDGE_WEIGHT = 2;

	localparam logic [1:0] OP_EROSION  = 2'd0;
	localparam logic [1:0] OP_DILATION = 2'd1;
	localparam logic [1:0] OP_SOBEL    = 2'd2;

	localparam logic [1:0] REG_OPERATION = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic pix;
		logic last;
	} result_t;

	// window bit index is column*3 + row; column 2 left, column 0 right, row 0 top
	function automatic logic sobel_edge(input logic [8:0] win);
		logic [2:0] gx_pos;
		logic [2:0] gx_neg;
		logic [2:0] gy_pos;
		logic [2:0] gy_neg;
		logic [2:0] gx_abs;
		logic [2:0] gy_abs;
		logic [3:0] mag;
		gx_pos = 3'(win[8]) + 3'(win[2]) + (win[5] ? 3'(EDGE_WEIGHT) : 3'd0);
		gx_neg = 3'(win[6]) + 3'(win[0]) + (win[3] ? 3'(EDGE_WEIGHT) : 3'd0);
		gy_pos = 3'(win[0]) + 3'(win[2]) + (win[1] ? 3'(EDGE_WEIGHT) : 3'd0);
		gy_neg = 3'(win[6]) + 3'(win[8]) + (win[7] ? 3'(EDGE_WEIGHT) : 3'd0);
		gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
		gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
		mag    = 4'(gx_abs) + 4'(gy_abs);
		return mag > 4'(SOBEL_LIMIT);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/bwf_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bwf_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/binary_window_filter_3x3.sv
// Top level of the streaming 3x3 binary window filter (erosion, dilation, binary Sobel).
// Throughput: one pixel or flush item per cycle while not stalled; a result passes the
// window stage and queue, width+1 items behind its pixel (set by the two line stores).
// The line store RAM has a registered read; a write bypass covers narrow rows.
// Reset clears counters and window and loads the default configuration, then a clearing
// pass over MAX_WIDTH (2048) addresses zeroes the line stores while in_stall stays high.
`default_nettype none

module binary_window_filter_3x3
	import bwf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output      logic [DATA_W-1:0] prdata,
	output      logic              pready,
	input  wire logic              in_valid,
	output      logic              in_stall,
	input  wire logic              mode,
	input  wire logic              pixel_in,
	output      logic              out_valid,
	input  wire logic              out_stall,
	output      logic              pixel_out,
	output      logic              frame_last
);

	// configuration
	logic [1:0]        op_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_EROSION;
			width_q  <= SIZE_W'(MAX_WIDTH);
			height_q <= SIZE_W'(MAX_HEIGHT);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OPERATION: op_q     <= pwdata[1:0];
				REG_WIDTH:     width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT:    height_q <= pwdata[SIZE_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OPERATION: prdata = DATA_W'(op_q);
			REG_WIDTH:     prdata = DATA_W'(width_q);
			REG_HEIGHT:    prdata = DATA_W'(height_q);
			default:       prdata = '0;
		endcase
	end

	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [SIZE_W:0]   w_plus1;

	always_comb begin
		if (width_q == '0)                       w_eff = SIZE_W'(1);
		else if (width_q > SIZE_W'(MAX_WIDTH))   w_eff = SIZE_W'(MAX_WIDTH);
		else                                     w_eff = width_q;
		if (height_q == '0)                      h_eff = SIZE_W'(1);
		else if (height_q > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
		else                                     h_eff = height_q;
	end

	assign w_plus1 = (SIZE_W+1)'(w_eff) + (SIZE_W+1)'(1);

	// counters
	logic [COL_W-1:0]     in_col_q;
	logic [ROW_W-1:0]     in_row_q;
	logic [COL_W-1:0]     out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [OWED_W-1:0]    owed_q;

	logic                 accept;
	logic                 restart;
	logic                 flush_go;
	logic                 do_push;
	logic                 emit;
	logic [COL_W-1:0]     col_e;
	logic [ROW_W-1:0]     row_e;
	logic [COL_W-1:0]     oc_e;
	logic [OUT_ROW_W-1:0] or_e;
	logic [OWED_W-1:0]    owed_e;
	logic [SIZE_W-1:0]    col_p1;
	logic [SIZE_W-1:0]    oc_p1;
	logic [SIZE_W-1:0]    or_p1;
	logic                 col_wrap;
	logic                 last_col;
	logic                 last_row;
	logic                 border;
	logic [COL_W-1:0]     in_col_d;
	logic [ROW_W-1:0]     in_row_d;
	logic [COL_W-1:0]     out_col_d;
	logic [OUT_ROW_W-1:0] out_row_d;
	logic [OWED_W-1:0]    owed_d;

	assign accept   = in_valid & ~in_stall;
	// a pixel after a complete frame starts a new one and drops what is still owed
	assign restart  = (mode == MODE_PIXEL) && (in_row_q >= ROW_W'(h_eff));
	assign flush_go = (mode == MODE_FLUSH) && (in_row_q >= ROW_W'(h_eff)) && (owed_q != '0);
	assign do_push  = accept & ((mode == MODE_PIXEL) | flush_go);

	assign col_e  = restart ? '0 : in_col_q;
	assign row_e  = restart ? '0 : in_row_q;
	assign oc_e   = restart ? '0 : out_col_q;
	assign or_e   = restart ? '0 : out_row_q;
	assign owed_e = restart ? '0 : owed_q;

	assign emit = (mode == MODE_PIXEL) ? ((SIZE_W+1)'(owed_e) >= w_plus1) : flush_go;

	assign col_p1   = SIZE_W'(col_e) + SIZE_W'(1);
	assign oc_p1    = SIZE_W'(oc_e) + SIZE_W'(1);
	assign or_p1    = SIZE_W'(or_e) + SIZE_W'(1);
	assign col_wrap = col_p1 >= w_eff;
	assign last_col = oc_p1 >= w_eff;
	assign last_row = or_p1 >= h_eff;
	assign border   = (or_e == '0) | last_row | (oc_e == '0) | last_col;

	always_comb begin
		in_col_d  = col_wrap ? '0 : col_p1[COL_W-1:0];
		in_row_d  = col_wrap ? row_e + ROW_W'(1) : row_e;
		out_col_d = oc_e;
		out_row_d = or_e;
		if (emit) begin
			out_col_d = last_col ? '0 : oc_p1[COL_W-1:0];
			if (last_col) begin
				out_row_d = last_row ? '0 : or_p1[OUT_ROW_W-1:0];
			end
		end
		if (mode == MODE_FLUSH)  owed_d = owed_q - OWED_W'(1);
		else if (emit)           owed_d = owed_e;
		else                     owed_d = owed_e + OWED_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			owed_q    <= '0;
		end else if (do_push) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
			owed_q    <= owed_d;
		end
	end

	// line stores: bit 1 upper row, bit 0 middle row
	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + COL_W'(1);
			if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// window stage
	logic             s1_v;
	logic             s1_emit;
	logic [COL_W-1:0] s1_addr;
	logic             s1_px;
	logic             s1_border;
	logic             s1_last;
	logic             s1_fwd;
	logic [1:0]       s1_fwd_data;
	logic [8:0]       win_q;

	logic [1:0]       ram_rdata;
	logic [1:0]       rd_s1;
	logic [1:0]       wdata_s1;
	logic [8:0]       win_d;
	logic             ram_we;
	logic [COL_W-1:0] ram_waddr;
	logic [1:0]       ram_wdata;
	logic             res_pix;
	logic             cross_and;
	logic             cross_or;

	// forward when the transaction ahead in the window stage wrote the column this one read
	assign rd_s1    = s1_fwd ? s1_fwd_data : ram_rdata;
	assign wdata_s1 = {rd_s1[0], s1_px};
	assign win_d    = {win_q[5:0], s1_px, rd_s1[0], rd_s1[1]};

	assign ram_we    = clr_busy_q | s1_v;
	assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr;
	assign ram_wdata = clr_busy_q ? 2'b00 : wdata_s1;

	bwf_ram #(
		.WIDTH (2),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (do_push),
		.raddr (col_e),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			win_q <= '0;
		end else begin
			s1_v <= do_push;
			if (s1_v) begin
				win_q <= win_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			s1_emit     <= emit;
			s1_addr     <= col_e;
			s1_px       <= (mode == MODE_PIXEL) ? pixel_in : 1'b0;
			s1_border   <= border;
			s1_last     <= last_row & last_col;
			s1_fwd      <= s1_v && (s1_addr == col_e);
			s1_fwd_data <= wdata_s1;
		end
	end

	assign cross_and = win_d[4] & win_d[7] & win_d[1] & win_d[3] & win_d[5];
	assign cross_or  = win_d[4] | win_d[7] | win_d[1] | win_d[3] | win_d[5];

	always_comb begin
		unique case (op_q)
			OP_EROSION:  res_pix = ~s1_border & cross_and;
			OP_DILATION: res_pix = s1_border ? win_d[4] : cross_or;
			OP_SOBEL:    res_pix = ~s1_border & sobel_edge(win_d);
			default:     res_pix = 1'b0;
		endcase
	end

	// output queue
	result_t    res_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       q_push;
	logic       q_pop;
	logic [2:0] load;
	logic [2:0] room_need;

	assign q_push = s1_v & s1_emit;
	assign q_pop  = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(q_push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			res_q[wr_ptr_q] <= '{pix: res_pix, last: s1_last};
		end
	end

	// hold input during the clearing pass and while the queue could not take the transactions in flight
	assign load      = 3'(cnt_q) + 3'(q_push);
	assign room_need = 3'd2 + 3'(q_pop);
	assign in_stall  = clr_busy_q | (load >= room_need);

	assign out_valid  = cnt_q != '0;
	assign pixel_out  = res_q[rd_ptr_q].pix;
	assign frame_last = res_q[rd_ptr_q].last;

endmodule

`default_nettype wire

// File: sim/binary_window_filter_3x3_tb.sv
// Self-checking testbench for the streaming 3x3 binary window filter.
`timescale 1ns / 100ps

module binary_window_filter_3x3_tb;
	import bwf_pkg::*;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         SETTLE_CYCLES  = 8;
	localparam int         WATCHDOG_LIMIT = 10000;
	localparam int         N_PHASES       = 9;
	localparam int         QUIET_PHASE    = 4;

	typedef struct packed {
		logic pix;
		logic last;
	} filtered_t;

	class morph_scoreboard;
		logic [1:0]        op_sel;
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		bit                upper_row [MAX_WIDTH];
		bit                middle_row [MAX_WIDTH];
		bit [8:0]          window;
		int unsigned       in_col;
		int unsigned       in_row;
		int unsigned       out_col;
		int unsigned       out_row;
		int unsigned       owed;
		filtered_t         filtered_q [$];
		int                errors;

		function new();
			op_sel     = OP_EROSION;
			width_reg  = SIZE_W'(MAX_WIDTH);
			height_reg = SIZE_W'(MAX_HEIGHT);
			foreach (upper_row[i]) begin
				upper_row[i]  = 1'b0;
				middle_row[i] = 1'b0;
			end
			window  = '0;
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
			owed    = 0;
			errors  = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_OPERATION: op_sel = value[1:0];
				REG_WIDTH:     width_reg = value[SIZE_W-1:0];
				REG_HEIGHT:    height_reg = value[SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned act_size(int unsigned v, int unsigned lim);
			if (v == 0)
				return 1;
			return (v > lim) ? lim : v;
		endfunction

		function int unsigned frame_width();
			return act_size(width_reg, MAX_WIDTH);
		endfunction

		function int unsigned frame_height();
			return act_size(height_reg, MAX_HEIGHT);
		endfunction

		// push one pixel down the column of the line stores and into the window
		function void shift_in(bit px, int unsigned w);
			int unsigned c;
			bit          top;
			bit          mid;
			c   = (in_col < MAX_WIDTH) ? in_col : 0;
			top = upper_row[c];
			mid = middle_row[c];
			upper_row[c]  = mid;
			middle_row[c] = px;
			window = {window[5:0], px, mid, top};
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		endfunction

		// window bit is column*3 + row: column 2 left, column 0 right, row 0 top
		function filtered_t filter_center(int unsigned w, int unsigned h);
			filtered_t r;
			bit        on_border;
			bit        c;
			bit        l;
			bit        rt;
			bit        up;
			bit        dn;
			int        gx;
			int        gy;
			on_border = (out_row == 0) || (out_row + 1 >= h) ||
			            (out_col == 0) || (out_col + 1 >= w);
			c  = window[4];
			l  = window[7];
			rt = window[1];
			up = window[3];
			dn = window[5];
			r.pix = 1'b0;
			case (op_sel)
				OP_EROSION: begin
					if (!on_border)
						r.pix = c & l & rt & up & dn;
				end
				OP_DILATION: begin
					r.pix = on_border ? c : (c | l | rt | up | dn);
				end
				OP_SOBEL: begin
					if (!on_border) begin
						gx = int'(window[8]) + int'(window[2]) + EDGE_WEIGHT * int'(window[5])
						   - int'(window[6]) - int'(window[0]) - EDGE_WEIGHT * int'(window[3]);
						gy = int'(window[0]) + int'(window[2]) + EDGE_WEIGHT * int'(window[1])
						   - int'(window[6]) - int'(window[8]) - EDGE_WEIGHT * int'(window[7]);
						if (gx < 0)
							gx = -gx;
						if (gy < 0)
							gy = -gy;
						r.pix = (gx + gy > SOBEL_LIMIT);
					end
				end
				default: ;
			endcase
			r.last = (out_row + 1 >= h) && (out_col + 1 >= w);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
				if (out_row >= h)
					out_row = 0;
			end
			return r;
		endfunction

		function void accept_item(logic m, logic px);
			int unsigned w;
			int unsigned h;
			filtered_t   res;
			w = frame_width();
			h = frame_height();
			if (m == MODE_PIXEL) begin
				// a pixel after a complete frame opens a new one; drop what was owed
				if (in_row >= h) begin
					in_row  = 0;
					in_col  = 0;
					out_row = 0;
					out_col = 0;
					owed    = 0;
				end
				shift_in(px, w);
				if (owed >= w + 1) begin
					res = filter_center(w, h);
					filtered_q = {filtered_q, res};
				end else begin
					owed++;
				end
			end else if (in_row >= h && owed != 0) begin
				shift_in(1'b0, w);
				owed--;
				res = filter_center(w, h);
				filtered_q = {filtered_q, res};
			end
		endfunction

		function void check_result(logic pix, logic last);
			filtered_t want;
			if (filtered_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: pixel_out=%b frame_last=%b", $time, pix, last);
				return;
			end
			want = filtered_q.pop_front();
			if (pix !== want.pix) begin
				errors++;
				$display("%0t: pixel_out mismatch: expected %b, actual %b", $time, want.pix, pix);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: frame_last mismatch: expected %b, actual %b", $time, want.last, last);
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic              mode      = MODE_PIXEL;
	logic              pixel_in  = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              pixel_out;
	logic              frame_last;

	morph_scoreboard sb;
	bit              gaps_on = 1'b1;
	int              quiet_cycles = 0;

	logic [1:0]  ph_op [N_PHASES] = '{OP_SOBEL, OP_EROSION, OP_DILATION, OP_UNUSED, OP_SOBEL,
	                                  OP_DILATION, OP_EROSION, OP_SOBEL, OP_DILATION};
	int unsigned ph_w [N_PHASES]     = '{5, 8, 0, 4, 6, 2, 7, 3, 2};
	int unsigned ph_h [N_PHASES]     = '{4, 6, 0, 4, 5, 7, 1, 3, 3};
	int unsigned ph_items [N_PHASES] = '{130, 130, 130, 130, 140, 130, 130, 30, 20};

	binary_window_filter_3x3 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < 30);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.accept_item(mode, pixel_in);
			if (out_valid && !out_stall)
				sb.check_result(pixel_out, frame_last);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// hold the input side until every expected result is back
	task automatic drain_wait();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.filtered_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input logic [1:0] op, input int unsigned w, input int unsigned h);
		drain_wait();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_OPERATION, DATA_W'(op));
		apb_write(REG_WIDTH, DATA_W'(w));
		apb_write(REG_HEIGHT, DATA_W'(h));
	endtask

	task automatic send_item(input logic m, input logic px);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		pixel_in <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_frame(input int unsigned w, input int unsigned h, input bit full_drain);
		int unsigned density;
		int unsigned n_flush;
		int unsigned i;
		density = $urandom_range(4) * 25;
		for (i = 0; i < w * h; i++) begin
			// a stray flush inside the frame must be ignored
			if ($urandom_range(99) < 4)
				send_item(MODE_FLUSH, 1'($urandom_range(1)));
			send_item(MODE_PIXEL, $urandom_range(99) < density);
		end
		if (full_drain || $urandom_range(3) != 0)
			n_flush = w + 1 + $urandom_range(2);
		else
			n_flush = $urandom_range(w);
		repeat (n_flush) send_item(MODE_FLUSH, 1'($urandom_range(1)));
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned n_frames;
		int          p;
		int          f;
		int          i;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// erosion on a 3x3 frame with stray flushes before and inside it
		configure(OP_EROSION, 3, 3);
		send_item(MODE_FLUSH, 1'b1);
		for (i = 0; i < 9; i++) begin
			if (i == 4)
				send_item(MODE_FLUSH, 1'b0);
			send_item(MODE_PIXEL, i != 0);
		end
		// switch to dilation with the frame complete but not drained
		configure(OP_DILATION, 3, 3);
		repeat (2) send_item(MODE_FLUSH, 1'b1);
		// switch again and overrun the partial drain with a new frame
		configure(OP_SOBEL, 3, 3);
		for (i = 0; i < 9; i++)
			send_item(MODE_PIXEL, i < 4 || i == 6);
		repeat (5) send_item(MODE_FLUSH, 1'b0);

		for (p = 0; p < N_PHASES; p++) begin
			configure(ph_op[p], ph_w[p], ph_h[p]);
			gaps_on  = (p != QUIET_PHASE);
			w        = sb.frame_width();
			h        = sb.frame_height();
			n_frames = ph_items[p] / (w * h + w + 1);
			if (n_frames == 0)
				n_frames = 1;
			for (f = 0; f < n_frames; f++) begin
				send_frame(w, h, f == n_frames - 1);
				if (f == 0 && n_frames > 1)
					drain_wait();
			end
		end

		drain_wait();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.filtered_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
rtl/core/bwf_pkg.sv
rtl/core/bwf_ram.sv
rtl/core/binary_window_filter_3x3.sv
sim/binary_window_filter_3x3_tb.sv
